FILE: design/clns_pkg.sv
// Package for the cell list neighbor search block: function codes, register
// indexes and the internal state machine type. No dependencies.
`timescale 1ns / 1ps
package clns_pkg;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  localparam logic [2:0] REG_CELLS_X = 3'd0;
  localparam logic [2:0] REG_CELLS_Y = 3'd1;
  localparam logic [2:0] REG_CELLS_Z = 3'd2;
  localparam logic [2:0] REG_RECIP_X = 3'd3;
  localparam logic [2:0] REG_RECIP_Y = 3'd4;
  localparam logic [2:0] REG_RECIP_Z = 3'd5;

  localparam int IDX_W   = 12;
  localparam int REG_W   = 24;
  localparam int CREG_W  = 5;
  localparam int SLOT_W  = 5;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL   = 8'b0000_0010,
    ST_ADDR  = 8'b0000_0100,
    ST_CNT   = 8'b0000_1000,
    ST_WALK  = 8'b0001_0000,
    ST_CLEAR = 8'b0010_0000,
    ST_EMIT  = 8'b0100_0000,
    ST_DRAIN = 8'b1000_0000
  } state_t;

endpackage

FILE: design/cell_list_neighbor_search_top.sv
// Top level of the periodic 3D cell list neighbor search block.
// Depends on clns_pkg and clns_coord.
`timescale 1ns / 1ps
// Usage:
//  - Input channel (in_valid/in_stall): one beat is clear, insert, query or the unused code.
//  - Result channel (out_valid/out_stall): one or more beats per input beat,
//    the final one carrying out_last. A query yields one beat per stored
//    member above the queried index, or one empty beat.
//  - Configuration (cfg_valid/cfg_ready): register index and data; write only
//    while idle. cfg_ready is always high.
//  - One item at a time. Insert: the position product is registered (ST_MUL),
//    the cell address formed (ST_ADDR), the cell count read (ST_CNT) and the
//    result emitted (ST_EMIT). Query: the same steps fetch the cell count,
//    then each stored member is read, then compared; earlier hits stream out
//    during the walk. Unused code and out-of-range slot: result registered
//    straight from idle. Clear sweeps the count memory one cell per cycle,
//    over all AXIS_CELLS_MAX^3 cells.
//  - The next input beat is taken only once the final result has left the
//    output register.
//  - Reset runs the same sweep before any input beat is taken; configuration
//    writes are taken meanwhile.
//  - A stalled result holds in the output register; the walk waits for it,
//    and a hit blocked behind it is read again.
module cell_list_neighbor_search_top #(
  parameter int AXIS_CELLS_MAX = 16,
  parameter int CELL_CAP       = 16,
  parameter int POS_BITS       = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_func,
  input  logic [11:0]           in_particle_index,
  input  logic [POS_BITS-1:0]   in_pos_x,
  input  logic [POS_BITS-1:0]   in_pos_y,
  input  logic [POS_BITS-1:0]   in_pos_z,
  input  logic [4:0]            in_neighbor_slot,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [11:0]           out_neighbor_index,
  output logic                  out_has_neighbor,
  output logic                  out_last,
  output logic                  out_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [23:0]           cfg_data
);
  localparam int AXIS_W  = (AXIS_CELLS_MAX > 1) ? $clog2(AXIS_CELLS_MAX) : 1;
  localparam int NCELLS  = AXIS_CELLS_MAX * AXIS_CELLS_MAX * AXIS_CELLS_MAX;
  localparam int CADDR_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int SLOT_BW = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
  localparam int CNT_W   = $clog2(CELL_CAP + 1);
  localparam int MADDR_W = CADDR_W + SLOT_BW;
  localparam int NMEM    = NCELLS * (1 << SLOT_BW);

  // Configuration registers
  logic [4:0]  cells_x_r, cells_y_r, cells_z_r;
  logic [23:0] recip_x_r, recip_y_r, recip_z_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r <= 5'd1; cells_y_r <= 5'd1; cells_z_r <= 5'd1;
      recip_x_r <= 24'd65536; recip_y_r <= 24'd65536; recip_z_r <= 24'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        clns_pkg::REG_CELLS_X: cells_x_r <= cfg_data[4:0];
        clns_pkg::REG_CELLS_Y: cells_y_r <= cfg_data[4:0];
        clns_pkg::REG_CELLS_Z: cells_z_r <= cfg_data[4:0];
        clns_pkg::REG_RECIP_X: recip_x_r <= cfg_data;
        clns_pkg::REG_RECIP_Y: recip_y_r <= cfg_data;
        clns_pkg::REG_RECIP_Z: recip_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective cell counts: zero acts as one, oversize clamps to the maximum
  function automatic logic [AXIS_W:0] eff_cells(input logic [4:0] r);
    logic [AXIS_W:0] v;
    if (r == 5'd0) v = (AXIS_W+1)'(1);
    else if (32'(r) > AXIS_CELLS_MAX) v = (AXIS_W+1)'(AXIS_CELLS_MAX);
    else v = (AXIS_W+1)'(r);
    return v;
  endfunction

  logic [AXIS_W:0] nx, ny, nz;
  assign nx = eff_cells(cells_x_r);
  assign ny = eff_cells(cells_y_r);
  assign nz = eff_cells(cells_z_r);

  // Captured item
  logic [1:0]          func_r;
  logic [11:0]         pidx_r;
  logic [POS_BITS-1:0] px_r, py_r, pz_r;
  logic [4:0]          slot_r;

  logic [AXIS_W-1:0] cx, cy, cz;
  clns_coord #(.POS_BITS(POS_BITS), .AXIS_W(AXIS_W)) u_cx (
    .clk(clk), .pos(px_r), .recip(recip_x_r), .ncell(nx), .coord(cx));
  clns_coord #(.POS_BITS(POS_BITS), .AXIS_W(AXIS_W)) u_cy (
    .clk(clk), .pos(py_r), .recip(recip_y_r), .ncell(ny), .coord(cy));
  clns_coord #(.POS_BITS(POS_BITS), .AXIS_W(AXIS_W)) u_cz (
    .clk(clk), .pos(pz_r), .recip(recip_z_r), .ncell(nz), .coord(cz));

  function automatic logic [AXIS_W-1:0] wrap(input logic [AXIS_W-1:0] c,
                                             input logic [1:0] off,
                                             input logic [AXIS_W:0] n);
    logic [AXIS_W-1:0] v;
    if (off == 2'd0) v = (c == '0) ? AXIS_W'(n - 1'b1) : c - 1'b1;
    else if (off == 2'd2) v = ((AXIS_W+1)'(c) + 1'b1 >= n) ? '0 : c + 1'b1;
    else v = c;
    return v;
  endfunction

  // Split the slot into its three base-3 digits by compare and subtract;
  // slots above 26 never reach the lookup
  logic [1:0] offx, offy, offz;
  logic [4:0] slot_rem;
  always_comb begin
    if (slot_r >= 5'd18) begin
      offx = 2'd2; slot_rem = slot_r - 5'd18;
    end else if (slot_r >= 5'd9) begin
      offx = 2'd1; slot_rem = slot_r - 5'd9;
    end else begin
      offx = 2'd0; slot_rem = slot_r;
    end
    if (slot_rem >= 5'd6) begin
      offy = 2'd2; offz = 2'(slot_rem - 5'd6);
    end else if (slot_rem >= 5'd3) begin
      offy = 2'd1; offz = 2'(slot_rem - 5'd3);
    end else begin
      offy = 2'd0; offz = 2'(slot_rem);
    end
  end

  logic                state_is_q;
  logic [AXIS_W-1:0]   wx, wy, wz;
  assign state_is_q = (func_r == clns_pkg::FUNC_QUERY);
  assign wx = state_is_q ? wrap(cx, offx, nx) : cx;
  assign wy = state_is_q ? wrap(cy, offy, ny) : cy;
  assign wz = state_is_q ? wrap(cz, offz, nz) : cz;

  // Memories: per-cell count and member list
  logic [CNT_W-1:0]  count_mem [NCELLS];
  logic [11:0]       member_mem [NMEM];
  logic [CNT_W-1:0]  cnt_rd_r;
  logic [11:0]       mem_rd_r;
  logic              cnt_we;
  logic [CADDR_W-1:0] cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;
  logic              mem_we;
  logic [MADDR_W-1:0] mem_raddr;

  clns_pkg::state_t  state_r, state_nxt;
  logic [CADDR_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              found_r, found_nxt;
  logic [11:0]       hold_r, hold_nxt;
  logic              rd_pend_r, rd_pend_nxt;

  always_ff @(posedge clk) begin
    cnt_rd_r <= count_mem[addr_r];
    if (cnt_we) count_mem[cnt_waddr] <= cnt_wdata;
    mem_rd_r <= member_mem[mem_raddr];
    if (mem_we) member_mem[{addr_r, SLOT_BW'(n_r)}] <= pidx_r;
  end

  assign mem_raddr = {addr_r, SLOT_BW'(k_r)};

  // Output register
  logic        ov_r, ov_nxt;
  logic [11:0] oidx_r, oidx_nxt;
  logic        ohas_r, ohas_nxt, olast_r, olast_nxt, ost_r, ost_nxt;
  logic        out_free;

  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != clns_pkg::ST_IDLE) || ov_r;

  always_comb begin
    state_nxt = state_r; addr_nxt = addr_r; n_nxt = n_r; k_nxt = k_r;
    found_nxt = found_r; hold_nxt = hold_r; rd_pend_nxt = 1'b0;
    ov_nxt = ov_r && out_stall;
    oidx_nxt = oidx_r; ohas_nxt = ohas_r; olast_nxt = olast_r; ost_nxt = ost_r;
    cnt_we = 1'b0; cnt_waddr = addr_r; cnt_wdata = '0; mem_we = 1'b0;
    unique case (state_r)
      clns_pkg::ST_IDLE: begin
        if (in_valid && !in_stall) begin
          if (in_func == clns_pkg::FUNC_CLEAR) begin
            addr_nxt = '0; state_nxt = clns_pkg::ST_CLEAR;
          end else if (in_func == clns_pkg::FUNC_NOP ||
                       (in_func == clns_pkg::FUNC_QUERY && in_neighbor_slot > 5'd26)) begin
            ov_nxt = 1'b1; oidx_nxt = '0; ohas_nxt = 1'b0; olast_nxt = 1'b1; ost_nxt = 1'b0;
          end else begin
            state_nxt = clns_pkg::ST_MUL;
          end
        end
      end
      clns_pkg::ST_MUL: state_nxt = clns_pkg::ST_ADDR;
      clns_pkg::ST_ADDR: begin
        addr_nxt = CADDR_W'((32'(wx) * AXIS_CELLS_MAX + 32'(wy)) * AXIS_CELLS_MAX + 32'(wz));
        state_nxt = clns_pkg::ST_CNT;
      end
      clns_pkg::ST_CNT: begin
        // wait until the registered count read of addr_r lands, then take it
        rd_pend_nxt = 1'b1;
        if (!rd_pend_r) begin
          state_nxt = clns_pkg::ST_CNT;
        end else begin
          rd_pend_nxt = 1'b0;
          n_nxt = cnt_rd_r; k_nxt = '0; found_nxt = 1'b0;
          if (func_r == clns_pkg::FUNC_INSERT) state_nxt = clns_pkg::ST_EMIT;
          else state_nxt = clns_pkg::ST_WALK;
        end
      end
      clns_pkg::ST_EMIT: begin
        if (out_free) begin
          ov_nxt = 1'b1; oidx_nxt = '0; ohas_nxt = 1'b0; olast_nxt = 1'b1;
          ost_nxt = (32'(n_r) >= CELL_CAP);
          if (32'(n_r) < CELL_CAP) begin
            mem_we = 1'b1; cnt_we = 1'b1; cnt_wdata = n_r + 1'b1;
          end
          state_nxt = clns_pkg::ST_IDLE;
        end
      end
      clns_pkg::ST_WALK: begin
        // issue the read of member k_r, compare it the cycle after; hold the
        // newest hit back until the next one shows whether it is the last
        if (rd_pend_r) begin
          if (mem_rd_r > pidx_r) begin
            if (!found_r) begin
              hold_nxt = mem_rd_r; found_nxt = 1'b1; k_nxt = k_r + 1'b1;
            end else if (out_free) begin
              ov_nxt = 1'b1; oidx_nxt = hold_r; ohas_nxt = 1'b1; ost_nxt = 1'b0;
              olast_nxt = 1'b0; hold_nxt = mem_rd_r; k_nxt = k_r + 1'b1;
            end
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else if (k_r >= n_r) begin
          state_nxt = clns_pkg::ST_DRAIN;
        end else begin
          rd_pend_nxt = 1'b1;
        end
      end
      clns_pkg::ST_DRAIN: begin
        // final beat: the held hit marked last, or an empty beat
        if (out_free) begin
          ov_nxt = 1'b1; oidx_nxt = found_r ? hold_r : '0; ohas_nxt = found_r;
          olast_nxt = 1'b1; ost_nxt = 1'b0;
          state_nxt = clns_pkg::ST_IDLE;
        end
      end
      clns_pkg::ST_CLEAR: begin
        cnt_we = 1'b1; cnt_wdata = '0;
        addr_nxt = addr_r + 1'b1;
        if (32'(addr_r) == NCELLS - 1) begin
          if (func_r == clns_pkg::FUNC_CLEAR) begin
            ov_nxt = 1'b1; oidx_nxt = '0; ohas_nxt = 1'b0; olast_nxt = 1'b1; ost_nxt = 1'b0;
          end
          state_nxt = clns_pkg::ST_IDLE;
        end
      end
      default: state_nxt = clns_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    // func code NOP after reset keeps the reset sweep from emitting a beat
    if (!rst_n) begin
      func_r <= clns_pkg::FUNC_NOP;
    end else if (in_valid && !in_stall) begin
      func_r <= in_func;
    end
    if (in_valid && !in_stall) begin
      pidx_r <= in_particle_index; slot_r <= in_neighbor_slot;
      px_r <= in_pos_x; py_r <= in_pos_y; pz_r <= in_pos_z;
    end
    oidx_r <= oidx_nxt; ohas_r <= ohas_nxt; olast_r <= olast_nxt; ost_r <= ost_nxt;
    n_r <= n_nxt; k_r <= k_nxt; found_r <= found_nxt; hold_r <= hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // reset sweep clears every count
      state_r <= clns_pkg::ST_CLEAR; addr_r <= '0; ov_r <= 1'b0; rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; addr_r <= addr_nxt; ov_r <= ov_nxt; rd_pend_r <= rd_pend_nxt;
    end
  end

  assign out_valid          = ov_r;
  assign out_neighbor_index = oidx_r;
  assign out_has_neighbor   = ohas_r;
  assign out_last           = olast_r;
  assign out_status         = ost_r;

  // A stalled beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r && $stable(oidx_r) && $stable(olast_r))
    else $error("result changed while stalled");
  // Every data beat carries has_neighbor and no status
  a_has: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ohas_r |-> !ost_r)
    else $error("data beat with status");
  // No input taken during a sweep
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == clns_pkg::ST_CLEAR |-> in_stall)
    else $error("input accepted while clearing");
endmodule

FILE: design/clns_coord.sv
// Cell coordinate along one axis: registered position times reciprocal, then
// clamp to the axis cell count. Depends on clns_pkg.
`timescale 1ns / 1ps
module clns_coord #(
  parameter int POS_BITS = 24,
  parameter int AXIS_W   = 4
) (
  input  logic                        clk,
  input  logic [POS_BITS-1:0]         pos,
  input  logic [clns_pkg::REG_W-1:0]  recip,
  input  logic [AXIS_W:0]             ncell,
  output logic [AXIS_W-1:0]           coord
);
  localparam int PROD_W = POS_BITS + clns_pkg::REG_W;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] hi;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(pos) * PROD_W'(recip);
  end

  always_comb begin
    hi = prod_r >> 32;
    if (hi >= PROD_W'(ncell)) coord = AXIS_W'(ncell - 1'b1);
    else coord = AXIS_W'(hi);
  end
endmodule

FILE: bench/tb_top.sv
// Self-checking bench for cell_list_neighbor_search_top: drives clear, insert,
// query and unused-code beats, predicts every result beat and compares it at the
// output. Depends on clns_pkg and the design sources.
`timescale 1ns / 1ps
module tb_top;

  localparam int AXIS = 16;
  localparam int CAP  = 16;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] pidx;
    logic [23:0] px;
    logic [23:0] py;
    logic [23:0] pz;
    logic [4:0]  slot;
  } op_t;

  typedef struct packed {
    logic [11:0] idx;
    logic        has;
    logic        last;
    logic        status;
  } hit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = '0;
  logic [11:0] in_particle_index = '0;
  logic [23:0] in_pos_x = '0;
  logic [23:0] in_pos_y = '0;
  logic [23:0] in_pos_z = '0;
  logic [4:0]  in_neighbor_slot = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_neighbor_index;
  logic        out_has_neighbor;
  logic        out_last;
  logic        out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  cell_list_neighbor_search_top dut (.*);

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the block: register file and cell storage.
  logic [4:0]  sh_cells [3];
  logic [23:0] sh_recip [3];
  int          occ [AXIS*AXIS*AXIS];
  logic [11:0] members [AXIS*AXIS*AXIS*CAP];

  op_t  pending_ops [$];
  hit_t expected_hits [$];
  op_t  cur;
  bit   beat_taken = 1'b0;
  bit   calm = 1'b0;      // suppress all idling and stalls while set
  bit   failed = 1'b0;

  function automatic int axis_span(logic [4:0] r);
    if (r == 0) return 1;
    if (r > AXIS) return AXIS;
    return int'(r);
  endfunction

  // Bin one position: exact 48-bit product, keep the integer part, clamp.
  function automatic int cell_coord(logic [23:0] pos, logic [23:0] recip, int n);
    logic [47:0] prod;
    prod = {24'b0, pos} * {24'b0, recip};
    if (int'(prod[47:32]) >= n) return n - 1;
    return int'(prod[47:32]);
  endfunction

  function automatic int wrap_axis(int c, int off, int n);
    if (off == 0) return (c == 0) ? n - 1 : c - 1;
    if (off == 2) return (c + 1 >= n) ? 0 : c + 1;
    return c;
  endfunction

  task automatic expect_hit(hit_t h);
    expected_hits.insert(expected_hits.size(), h);
  endtask

  // Work out the result beats of one accepted input beat and queue them.
  task automatic predict_beat(op_t op);
    int nx, ny, nz, cx, cy, cz, addr, total, seen;
    hit_t h;
    nx = axis_span(sh_cells[0]);
    ny = axis_span(sh_cells[1]);
    nz = axis_span(sh_cells[2]);
    h = '{idx: '0, has: 1'b0, last: 1'b1, status: 1'b0};
    case (op.func)
      clns_pkg::FUNC_CLEAR: begin
        foreach (occ[i]) occ[i] = 0;
        expect_hit(h);
      end
      clns_pkg::FUNC_INSERT: begin
        cx = cell_coord(op.px, sh_recip[0], nx);
        cy = cell_coord(op.py, sh_recip[1], ny);
        cz = cell_coord(op.pz, sh_recip[2], nz);
        addr = (cx * AXIS + cy) * AXIS + cz;
        if (occ[addr] >= CAP) begin
          h.status = 1'b1;
        end else begin
          members[addr*CAP + occ[addr]] = op.pidx;
          occ[addr]++;
        end
        expect_hit(h);
      end
      clns_pkg::FUNC_QUERY: begin
        total = 0;
        if (op.slot <= 26) begin
          cx = wrap_axis(cell_coord(op.px, sh_recip[0], nx), op.slot / 9, nx);
          cy = wrap_axis(cell_coord(op.py, sh_recip[1], ny), (op.slot / 3) % 3, ny);
          cz = wrap_axis(cell_coord(op.pz, sh_recip[2], nz), op.slot % 3, nz);
          addr = (cx * AXIS + cy) * AXIS + cz;
          for (int k = 0; k < occ[addr]; k++) begin
            if (members[addr*CAP + k] > op.pidx) total++;
          end
          seen = 0;
          for (int k = 0; k < occ[addr]; k++) begin
            if (members[addr*CAP + k] > op.pidx) begin
              seen++;
              expect_hit('{idx: members[addr*CAP + k], has: 1'b1,
                           last: (seen == total), status: 1'b0});
            end
          end
        end
        if (total == 0) expect_hit(h);
      end
      default: expect_hit(h);
    endcase
  endtask

  // Driver: advance to the next beat once the current one is taken, hold otherwise.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      if (pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
        cur = pending_ops.pop_front();
        in_valid          <= 1'b1;
        in_func           <= cur.func;
        in_particle_index <= cur.pidx;
        in_pos_x          <= cur.px;
        in_pos_y          <= cur.py;
        in_pos_z          <= cur.pz;
        in_neighbor_slot  <= cur.slot;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 23);
  end

  // Monitor: predict on each accepted input beat, then check each result beat.
  always @(posedge clk) begin
    beat_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_beat(cur);
      end
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          $error("result beat with nothing expected: index %0d", out_neighbor_index);
          failed = 1'b1;
        end else begin
          hit_t e;
          e = expected_hits.pop_front();
          if (out_neighbor_index !== e.idx) begin
            $error("neighbor_index: expected %0d, got %0d", e.idx, out_neighbor_index);
            failed = 1'b1;
          end
          if (out_has_neighbor !== e.has) begin
            $error("has_neighbor: expected %0d, got %0d", e.has, out_has_neighbor);
            failed = 1'b1;
          end
          if (out_last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_last);
            failed = 1'b1;
          end
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            failed = 1'b1;
          end
        end
      end
    end
  end

  task automatic push_op(logic [1:0] f, logic [11:0] p, logic [23:0] x,
                         logic [23:0] y, logic [23:0] z, logic [4:0] s);
    pending_ops.insert(pending_ops.size(),
                       '{func: f, pidx: p, px: x, py: y, pz: z, slot: s});
  endtask

  // Register write; hold valid until the block takes it.
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= clns_pkg::REG_CELLS_Z) sh_cells[2'(idx)] = val[4:0];
    else sh_recip[2'(idx - clns_pkg::REG_RECIP_X)] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(logic [4:0] gx, logic [4:0] gy, logic [4:0] gz,
                          logic [23:0] rx, logic [23:0] ry, logic [23:0] rz);
    write_reg(clns_pkg::REG_CELLS_X, {19'b0, gx});
    write_reg(clns_pkg::REG_CELLS_Y, {19'b0, gy});
    write_reg(clns_pkg::REG_CELLS_Z, {19'b0, gz});
    write_reg(clns_pkg::REG_RECIP_X, rx);
    write_reg(clns_pkg::REG_RECIP_Y, ry);
    write_reg(clns_pkg::REG_RECIP_Z, rz);
  endtask

  // Block until every beat went in and every result came back, then settle.
  task automatic drain();
    while (pending_ops.size() != 0 || in_valid || expected_hits.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_pos(int span);
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    return 24'($urandom_range(0, span));
  endfunction

  // Mostly well-formed: optional clear, a fill of inserts, then queries with a
  // sprinkling of late inserts, out-of-range slots and the unused code.
  task automatic random_phase(int count, int span, bit with_clear);
    int r;
    if (with_clear)
      push_op(clns_pkg::FUNC_CLEAR, 12'($urandom), 24'($urandom), 24'($urandom),
              24'($urandom), 5'($urandom));
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (i < count * 2 / 5 || r < 8)
        push_op(clns_pkg::FUNC_INSERT, 12'($urandom), rand_pos(span), rand_pos(span),
                rand_pos(span), 5'($urandom));
      else if (r < 11)
        push_op(clns_pkg::FUNC_NOP, 12'($urandom), 24'($urandom), 24'($urandom),
                24'($urandom), 5'($urandom));
      else
        push_op(clns_pkg::FUNC_QUERY, 12'($urandom), rand_pos(span), rand_pos(span),
                rand_pos(span),
                (r < 16) ? 5'($urandom_range(27, 31)) : 5'($urandom_range(0, 26)));
    end
  endtask

  initial begin
    sh_cells = '{5'd1, 5'd1, 5'd1};
    sh_recip = '{24'd65536, 24'd65536, 24'd65536};
    foreach (occ[i]) occ[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset grid (one cell): overfill the cell, extremes of index,
    // wrap slots, bad slots, the unused code, and a query after clear.
    push_op(clns_pkg::FUNC_INSERT, 12'd0, 24'h0, 24'h0, 24'h0, 5'd0);
    push_op(clns_pkg::FUNC_INSERT, 12'hFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 5'd31);
    for (int i = 0; i < 16; i++)
      push_op(clns_pkg::FUNC_INSERT, (i == 3) ? 12'd100 : 12'd100 + 12'(i * 257),
              24'($urandom), 24'($urandom), 24'($urandom), 5'd0);
    push_op(clns_pkg::FUNC_QUERY, 12'd0, 24'h0, 24'h0, 24'h0, 5'd0);
    push_op(clns_pkg::FUNC_QUERY, 12'd500, 24'hFFFFFF, 24'h0, 24'h0, 5'd26);
    push_op(clns_pkg::FUNC_QUERY, 12'hFFF, 24'h0, 24'h0, 24'h0, 5'd13);
    push_op(clns_pkg::FUNC_QUERY, 12'd0, 24'h0, 24'h0, 24'h0, 5'd27);
    push_op(clns_pkg::FUNC_NOP, 12'hFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 5'd31);
    push_op(clns_pkg::FUNC_CLEAR, 12'd0, 24'h0, 24'h0, 24'h0, 5'd0);
    push_op(clns_pkg::FUNC_QUERY, 12'd0, 24'h0, 24'h0, 24'h0, 5'd13);
    drain();

    // Largest grid, coordinates packed into the lowest cells for density.
    set_grid(5'd16, 5'd16, 5'd16, 24'd4096, 24'd4096, 24'd4096);
    random_phase(100, 24'h1FFFFF, 1'b0);
    drain();

    // Zero and oversized cell registers, zero and full-scale reciprocals;
    // run this phase with no idling at all.
    calm = 1'b1;
    set_grid(5'd0, 5'd31, 5'd3, 24'd0, 24'hFFFFFF, 24'd768);
    random_phase(100, 24'hFFFFFF, 1'b1);
    drain();
    calm = 1'b0;

    // Small grid: query slots wrap on every axis.
    set_grid(5'd2, 5'd3, 5'd2, 24'd512, 24'd768, 24'd512);
    random_phase(100, 24'hFFFFFF, 1'b1);
    drain();

    set_grid(5'd5, 5'd1, 5'd16, 24'($urandom_range(0, 24'hFFFF)), 24'd65536,
             24'($urandom_range(24'd1024, 24'd8192)));
    random_phase(100, 24'h3FFFFF, 1'b0);
    drain();

    if (!failed) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("tb_top failed");
    $finish;
  end

endmodule
